[rtl/sttok_pkg.sv]
// Package for the source tokenizer: token kinds, scan modes, default sizes
// and the character-class and keyword helpers. No dependencies.
package sttok_pkg;

  // Default sizes handed to the top level parameters.
  localparam int LEXEME_LIMIT_DEF = 99;
  localparam int LINE_BITS_DEF    = 16;
  localparam int OFFSET_BITS_DEF  = 32;

  // Fixed field widths of a token.
  localparam int KIND_BITS = 6;
  localparam int LEN_BITS  = 7;
  localparam int LEN_WIDE  = 8;   // internal length, holds lexeme limits up to 255
  localparam int KW_BITS   = 48;  // last six identifier bytes

  // Depth of the token queue in front of the result channel.
  localparam int QUEUE_DEPTH = 4;

  typedef logic [KIND_BITS-1:0] kind_t;

  localparam kind_t K_INT    = 6'd0;
  localparam kind_t K_FLOAT  = 6'd1;
  localparam kind_t K_STRING = 6'd2;
  localparam kind_t K_BOOL   = 6'd3;
  localparam kind_t K_IDENT  = 6'd4;
  localparam kind_t K_LSTR   = 6'd5;
  localparam kind_t K_LINT   = 6'd6;
  localparam kind_t K_LFLOAT = 6'd7;
  localparam kind_t K_TRUE   = 6'd8;
  localparam kind_t K_FALSE  = 6'd9;
  localparam kind_t K_PLUS   = 6'd10;
  localparam kind_t K_SPLUS  = 6'd11;
  localparam kind_t K_MINUS  = 6'd12;
  localparam kind_t K_SMINUS = 6'd13;
  localparam kind_t K_MULT   = 6'd14;
  localparam kind_t K_DIV    = 6'd15;
  localparam kind_t K_ASSIGN = 6'd16;
  localparam kind_t K_EQUAL  = 6'd17;
  localparam kind_t K_GT     = 6'd18;
  localparam kind_t K_GE     = 6'd19;
  localparam kind_t K_LT     = 6'd20;
  localparam kind_t K_LE     = 6'd21;
  localparam kind_t K_NE     = 6'd22;
  localparam kind_t K_SEMI   = 6'd23;
  localparam kind_t K_LPAREN = 6'd24;
  localparam kind_t K_RPAREN = 6'd25;
  localparam kind_t K_LBRACE = 6'd26;
  localparam kind_t K_RBRACE = 6'd27;
  localparam kind_t K_COMMA  = 6'd28;
  localparam kind_t K_IF     = 6'd29;
  localparam kind_t K_WHILE  = 6'd30;
  localparam kind_t K_FOR    = 6'd31;
  localparam kind_t K_PROC   = 6'd32;
  localparam kind_t K_WRITE  = 6'd33;
  localparam kind_t K_READ   = 6'd34;
  localparam kind_t K_EOF    = 6'd35;
  localparam kind_t K_ERROR  = 6'd36;

  // Scanner modes: what kind of token is open.
  typedef enum logic [3:0] {
    M_IDLE,
    M_STR,
    M_INT,
    M_FRAC,
    M_IDENT,
    M_MINUS,
    M_PLUS,
    M_EQ,
    M_BANG
  } mode_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Kind of a token that is complete after its single byte.
  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h2A:   k = K_MULT;
      8'h2F:   k = K_DIV;
      8'h3B:   k = K_SEMI;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h3C:   k = K_LT;
      8'h3E:   k = K_GT;
      8'h2C:   k = K_COMMA;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  // Keyword lookup on the packed identifier bytes and the lexeme length.
  function automatic kind_t kw_lookup(input logic [KW_BITS-1:0] word,
                                      input logic [LEN_WIDE-1:0] len);
    kind_t k;
    k = K_IDENT;
    if (len == 8'd2 && word == 48'h6966)         k = K_IF;
    if (len == 8'd3 && word == 48'h696E74)       k = K_INT;
    if (len == 8'd3 && word == 48'h666F72)       k = K_FOR;
    if (len == 8'd4 && word == 48'h626F6F6C)     k = K_BOOL;
    if (len == 8'd4 && word == 48'h74727565)     k = K_TRUE;
    if (len == 8'd4 && word == 48'h72656164)     k = K_READ;
    if (len == 8'd4 && word == 48'h70726F63)     k = K_PROC;
    if (len == 8'd5 && word == 48'h666C6F6174)   k = K_FLOAT;
    if (len == 8'd5 && word == 48'h66616C7365)   k = K_FALSE;
    if (len == 8'd5 && word == 48'h7772697465)   k = K_WRITE;
    if (len == 8'd5 && word == 48'h7768696C65)   k = K_WHILE;
    if (len == 8'd6 && word == 48'h737472696E67) k = K_STRING;
    return k;
  endfunction

endpackage

[rtl/sttok_if.sv]
// Valid/ready channel interfaces for source bytes and tokens.
// Depends on sttok_pkg for the fixed token field widths and the default sizes.
interface sttok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface sttok_out_if #(
  parameter int LINE_BITS   = sttok_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = sttok_pkg::OFFSET_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [sttok_pkg::KIND_BITS-1:0] token_kind;
  logic [LINE_BITS-1:0]            start_line;
  logic [OFFSET_BITS-1:0]          start_offset;
  logic [sttok_pkg::LEN_BITS-1:0]  lexeme_length;
  logic                            last_in_run;

  modport source (output valid, output token_kind, output start_line,
                  output start_offset, output lexeme_length, output last_in_run,
                  input ready);
  modport sink   (input valid, input token_kind, input start_line,
                  input start_offset, input lexeme_length, input last_in_run,
                  output ready);
endinterface

[rtl/sttok_core.sv]
// Scanner core: mode, counters and positions, updated once per accepted item.
// Produces zero, one or two tokens per item. Depends on sttok_pkg.
module sttok_core #(
  parameter int LEXEME_LIMIT = sttok_pkg::LEXEME_LIMIT_DEF,
  parameter int LINE_BITS    = sttok_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS  = sttok_pkg::OFFSET_BITS_DEF,
  parameter int TOK_BITS     = sttok_pkg::KIND_BITS + LINE_BITS + OFFSET_BITS
                               + sttok_pkg::LEN_BITS + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          char_byte,
  input  logic                end_of_input,
  output logic [1:0]          emit_n,
  output logic [TOK_BITS-1:0] tok_a,
  output logic [TOK_BITS-1:0] tok_b
);
  import sttok_pkg::*;

  localparam int CNT_BITS = $clog2(LEXEME_LIMIT + 1);

  typedef struct packed {
    kind_t                kind;
    logic [LINE_BITS-1:0]   line;
    logic [OFFSET_BITS-1:0] offset;
    logic [LEN_BITS-1:0]    len;
    logic                   last;
  } tok_t;

  mode_t                  mode_r, mode_nxt;
  logic [KW_BITS-1:0]     kw_r, kw_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] tso_r, tso_nxt;
  logic [LINE_BITS-1:0]   tsl_r, tsl_nxt;

  logic [CNT_BITS-1:0] cnt_inc;
  logic [LEN_WIDE-1:0] cnt_len;
  logic [LEN_WIDE-1:0] inc_len;
  logic                restart;

  // First emission closes the open token; second starts at the current byte.
  logic                ce_v, se_v;
  kind_t               ce_kind, se_kind;
  logic [LEN_WIDE-1:0] ce_len, se_len;
  tok_t                t_close, t_start;

  assign cnt_inc = (cnt_r < CNT_BITS'(LEXEME_LIMIT)) ? cnt_r + 1'b1 : cnt_r;
  assign cnt_len = LEN_WIDE'(cnt_r);
  assign inc_len = LEN_WIDE'(cnt_inc);

  // Next-state and emission logic for one item.
  always_comb begin
    mode_nxt = mode_r;
    kw_nxt   = kw_r;
    cnt_nxt  = cnt_r;
    line_nxt = line_r;
    pos_nxt  = pos_r;
    tso_nxt  = tso_r;
    tsl_nxt  = tsl_r;
    ce_v     = 1'b0;
    ce_kind  = K_ERROR;
    ce_len   = LEN_WIDE'(1);
    se_v     = 1'b0;
    se_kind  = K_ERROR;
    se_len   = LEN_WIDE'(1);
    restart  = 1'b0;
    if (accept && end_of_input) begin
      // Flush whatever is open, then the end-of-file token.
      ce_v = (mode_r != M_IDLE);
      unique case (mode_r)
        M_STR:   begin ce_kind = K_ERROR;  ce_len = cnt_len; end
        M_INT:   begin ce_kind = K_LINT;   ce_len = cnt_len; end
        M_FRAC:  begin ce_kind = K_LFLOAT; ce_len = cnt_len; end
        M_IDENT: begin ce_kind = kw_lookup(kw_r, cnt_len); ce_len = cnt_len; end
        M_MINUS: ce_kind = K_MINUS;
        M_PLUS:  ce_kind = K_PLUS;
        M_EQ:    ce_kind = K_ASSIGN;
        M_BANG:  ce_kind = K_ERROR;
        default: ce_kind = K_ERROR;
      endcase
      se_v     = 1'b1;
      se_kind  = K_EOF;
      se_len   = '0;
      tsl_nxt  = line_r;
      tso_nxt  = pos_r;
      cnt_nxt  = '0;
      mode_nxt = M_IDLE;
    end else if (accept) begin
      // Continue the open token, or mark the byte as the start of a new one.
      unique case (mode_r)
        M_STR: begin
          cnt_nxt = cnt_inc;
          if (char_byte == 8'h22) begin
            ce_v = 1'b1; ce_kind = K_LSTR; ce_len = inc_len; mode_nxt = M_IDLE;
          end
        end
        M_INT: begin
          if (is_digit(char_byte)) begin
            cnt_nxt = cnt_inc;
          end else if (char_byte == 8'h2E) begin
            cnt_nxt = cnt_inc; mode_nxt = M_FRAC;
          end else begin
            ce_v = 1'b1; ce_kind = K_LINT; ce_len = cnt_len; restart = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(char_byte)) begin
            cnt_nxt = cnt_inc;
          end else begin
            ce_v = 1'b1; ce_kind = K_LFLOAT; ce_len = cnt_len; restart = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(char_byte) || is_digit(char_byte) || char_byte == 8'h5F) begin
            cnt_nxt = cnt_inc;
            kw_nxt  = {kw_r[KW_BITS-9:0], char_byte};
          end else begin
            ce_v = 1'b1; ce_kind = kw_lookup(kw_r, cnt_len); ce_len = cnt_len;
            restart = 1'b1;
          end
        end
        M_MINUS: begin
          if (is_digit(char_byte)) begin
            cnt_nxt = cnt_inc; mode_nxt = M_INT;
          end else if (char_byte == 8'h2D) begin
            ce_v = 1'b1; ce_kind = K_SMINUS; ce_len = LEN_WIDE'(2); mode_nxt = M_IDLE;
          end else begin
            ce_v = 1'b1; ce_kind = K_MINUS; restart = 1'b1;
          end
        end
        M_PLUS: begin
          if (char_byte == 8'h2B) begin
            ce_v = 1'b1; ce_kind = K_SPLUS; ce_len = LEN_WIDE'(2); mode_nxt = M_IDLE;
          end else begin
            ce_v = 1'b1; ce_kind = K_PLUS; restart = 1'b1;
          end
        end
        M_EQ: begin
          ce_v = 1'b1;
          if (char_byte == 8'h3D) begin
            ce_kind = K_EQUAL; ce_len = LEN_WIDE'(2); mode_nxt = M_IDLE;
          end else if (char_byte == 8'h3C) begin
            ce_kind = K_LE; ce_len = LEN_WIDE'(2); mode_nxt = M_IDLE;
          end else if (char_byte == 8'h3E) begin
            ce_kind = K_GE; ce_len = LEN_WIDE'(2); mode_nxt = M_IDLE;
          end else begin
            ce_kind = K_ASSIGN; restart = 1'b1;
          end
        end
        M_BANG: begin
          ce_v = 1'b1;
          if (char_byte == 8'h3D) begin
            ce_kind = K_NE; ce_len = LEN_WIDE'(2); mode_nxt = M_IDLE;
          end else begin
            ce_kind = K_ERROR; restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase

      // A new token begins at this byte.
      if (restart) begin
        tsl_nxt  = line_r;
        tso_nxt  = pos_r;
        cnt_nxt  = CNT_BITS'(1);
        mode_nxt = M_IDLE;
        if (is_space(char_byte)) begin
          mode_nxt = M_IDLE;
        end else if (char_byte == 8'h22) begin
          mode_nxt = M_STR;
        end else if (is_digit(char_byte)) begin
          mode_nxt = M_INT;
        end else if (char_byte == 8'h2D) begin
          mode_nxt = M_MINUS;
        end else if (is_alpha(char_byte) || char_byte == 8'h5F) begin
          mode_nxt = M_IDENT;
          kw_nxt   = KW_BITS'(char_byte);
        end else if (char_byte == 8'h2B) begin
          mode_nxt = M_PLUS;
        end else if (char_byte == 8'h3D) begin
          mode_nxt = M_EQ;
        end else if (char_byte == 8'h21) begin
          mode_nxt = M_BANG;
        end else begin
          se_v    = 1'b1;
          se_kind = single_kind(char_byte);
        end
      end

      // Position advances; the line count saturates.
      pos_nxt = pos_r + 1'b1;
      if (char_byte == 8'h0A && line_r != '1) begin
        line_nxt = line_r + 1'b1;
      end
    end
  end

  // Token records and their packing order.
  always_comb begin
    t_close.kind   = ce_kind;
    t_close.line   = tsl_r;
    t_close.offset = tso_r;
    t_close.len    = ce_len[LEN_BITS-1:0];
    t_close.last   = !se_v;
    t_start.kind   = se_kind;
    t_start.line   = line_r;
    t_start.offset = pos_r;
    t_start.len    = se_len[LEN_BITS-1:0];
    t_start.last   = 1'b1;
    emit_n = 2'(ce_v) + 2'(se_v);
    tok_a  = ce_v ? TOK_BITS'(t_close) : TOK_BITS'(t_start);
    tok_b  = TOK_BITS'(t_start);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      kw_r   <= '0;
      cnt_r  <= '0;
      line_r <= LINE_BITS'(1);
      pos_r  <= '0;
      tso_r  <= '0;
      tsl_r  <= LINE_BITS'(1);
    end else begin
      mode_r <= mode_nxt;
      kw_r   <= kw_nxt;
      cnt_r  <= cnt_nxt;
      line_r <= line_nxt;
      pos_r  <= pos_nxt;
      tso_r  <= tso_nxt;
      tsl_r  <= tsl_nxt;
    end
  end

endmodule

[rtl/sttok_queue.sv]
// Token queue between the scanner and the result channel; takes up to two
// tokens per cycle and hands out one. Depends on sttok_pkg.
module sttok_queue #(
  parameter int TOK_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  logic [TOK_BITS-1:0] push_a,
  input  logic [TOK_BITS-1:0] push_b,
  output logic                room,
  output logic                head_valid,
  input  logic                pop,
  output logic [TOK_BITS-1:0] head
);
  import sttok_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [TOK_BITS-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_next_slot;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                do_pop;

  // Room for two tokens means any item can be taken.
  assign room       = (cnt_r <= CNT_BITS'(QUEUE_DEPTH - 2));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];
  assign do_pop     = pop && head_valid;

  assign wr_next_slot = wr_r + 1'b1;

  always_comb begin
    wr_nxt  = wr_r + PTR_BITS'(push_n);
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + CNT_BITS'(push_n) - CNT_BITS'(do_pop);
  end

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_next_slot] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/source_tokenizer.sv]
// Top level of the streaming source tokenizer: scanner core plus token queue.
// Depends on sttok_pkg, sttok_if, sttok_core and sttok_queue.
//
//   Channel   Dir  Moves                        Transfer when
//   in_ch     in   char_byte, end_of_input      valid && ready
//   out_ch    out  token kind, line, offset,    valid && ready
//                  length, last_in_run
//
// One byte is taken per cycle; the scanner state updates in that same cycle
// and the zero, one or two tokens it yields enter a four-entry queue.
// in_ch.ready is high while the queue has room for two tokens, so the byte
// rate is one per cycle while the sink takes one token per cycle, except in
// a run of bytes that each yield two tokens; those wait for the queue to drain.
// A token is registered in the queue when the byte that completes it is taken.
// Reset (synchronous, active low) empties the queue and returns the scanner
// to idle at line 1, offset 0.
module source_tokenizer #(
  parameter int LEXEME_LIMIT = sttok_pkg::LEXEME_LIMIT_DEF,
  parameter int LINE_BITS    = sttok_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS  = sttok_pkg::OFFSET_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  sttok_in_if.sink    in_ch,
  sttok_out_if.source out_ch
);
  import sttok_pkg::*;

  localparam int TOK_BITS = KIND_BITS + LINE_BITS + OFFSET_BITS + LEN_BITS + 1;

  typedef struct packed {
    kind_t                  kind;
    logic [LINE_BITS-1:0]   line;
    logic [OFFSET_BITS-1:0] offset;
    logic [LEN_BITS-1:0]    len;
    logic                   last;
  } tok_t;

  logic                accept;
  logic [1:0]          emit_n;
  logic [TOK_BITS-1:0] tok_a, tok_b, head;
  logic                room;
  tok_t                head_tok;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  sttok_core #(
    .LEXEME_LIMIT (LEXEME_LIMIT),
    .LINE_BITS    (LINE_BITS),
    .OFFSET_BITS  (OFFSET_BITS),
    .TOK_BITS     (TOK_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .char_byte    (in_ch.char_byte),
    .end_of_input (in_ch.end_of_input),
    .emit_n       (emit_n),
    .tok_a        (tok_a),
    .tok_b        (tok_b)
  );

  sttok_queue #(
    .TOK_BITS (TOK_BITS)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (emit_n),
    .push_a     (tok_a),
    .push_b     (tok_b),
    .room       (room),
    .head_valid (out_ch.valid),
    .pop        (out_ch.ready),
    .head       (head)
  );

  // Unpack the queue head onto the result channel.
  assign head_tok             = tok_t'(head);
  assign out_ch.token_kind    = head_tok.kind;
  assign out_ch.start_line    = head_tok.line;
  assign out_ch.start_offset  = head_tok.offset;
  assign out_ch.lexeme_length = head_tok.len;
  assign out_ch.last_in_run   = head_tok.last;

endmodule

[dv/source_tokenizer_tb.sv]
`timescale 1ns / 1ps
// Testbench for source_tokenizer: a self-checking token scoreboard with its own lexer model.
// Depends on sttok_pkg, sttok_if and the source_tokenizer RTL.
module source_tokenizer_tb;
  import sttok_pkg::*;

  localparam int LINE_W        = LINE_BITS_DEF;
  localparam int OFFSET_W      = OFFSET_BITS_DEF;
  localparam int LEX_LIMIT     = LEXEME_LIMIT_DEF;
  localparam int RANDOM_ITEMS  = 500;
  // A correct run waits between transfers at most for a source gap plus a sink
  // stall plus the pipeline.
  localparam int WATCHDOG      = 1000;
  localparam int DRAIN_CYCLES  = 20;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  typedef struct packed {
    kind_t               kind;
    logic [LINE_W-1:0]   line_no;
    logic [OFFSET_W-1:0] offset;
    logic [6:0]          len;
    logic                last;
  } token_t;

  // Lexer model plus the queue of tokens still to come out of the block.
  class token_scoreboard;
    string kw_text[12] = '{"int", "float", "string", "bool", "true", "false",
                           "if", "write", "read", "while", "for", "proc"};
    kind_t kw_kind[12] = '{K_INT, K_FLOAT, K_STRING, K_BOOL, K_TRUE, K_FALSE,
                           K_IF, K_WRITE, K_READ, K_WHILE, K_FOR, K_PROC};

    mode_t               mode     = M_IDLE;
    logic [47:0]         kw_buf   = '0;
    int                  lex_cnt  = 0;
    logic [LINE_W-1:0]   line_no  = LINE_W'(1);
    logic [OFFSET_W-1:0] pos      = '0;
    logic [OFFSET_W-1:0] tok_off  = '0;
    logic [LINE_W-1:0]   tok_line = LINE_W'(1);

    token_t expected_tokens[$];
    token_t step_tokens[$];
    int     fails = 0;

    function bit digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit letter_ch(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit blank_ch(logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function void add(kind_t k, int n);
      token_t t;
      t.kind    = k;
      t.line_no = tok_line;
      t.offset  = tok_off;
      t.len     = n[6:0];
      t.last    = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function void bump();
      if (lex_cnt < LEX_LIMIT) lex_cnt++;
    endfunction

    // Identifier or keyword, from the length and the last six bytes.
    function kind_t word_kind();
      logic [47:0] packed_word;
      for (int k = 0; k < 12; k++) begin
        if (kw_text[k].len() != lex_cnt) continue;
        packed_word = '0;
        for (int i = 0; i < kw_text[k].len(); i++)
          packed_word = {packed_word[39:0], kw_text[k][i]};
        if (packed_word == kw_buf) return kw_kind[k];
      end
      return K_IDENT;
    endfunction

    // End of input: an open token is emitted as it stands.
    function void flush();
      case (mode)
        M_STR:   add(K_ERROR, lex_cnt);
        M_INT:   add(K_LINT, lex_cnt);
        M_FRAC:  add(K_LFLOAT, lex_cnt);
        M_IDENT: add(word_kind(), lex_cnt);
        M_MINUS: add(K_MINUS, 1);
        M_PLUS:  add(K_PLUS, 1);
        M_EQ:    add(K_ASSIGN, 1);
        M_BANG:  add(K_ERROR, 1);
        default: ;
      endcase
      mode = M_IDLE;
    endfunction

    function void open_token(logic [7:0] c);
      tok_line = line_no;
      tok_off  = pos;
      lex_cnt  = 1;
      if (blank_ch(c)) return;
      if (c == CH_QUOTE) begin
        mode = M_STR;
      end else if (digit_ch(c)) begin
        mode = M_INT;
      end else if (c == CH_MINUS) begin
        mode = M_MINUS;
      end else if (letter_ch(c) || c == CH_UNDER) begin
        mode   = M_IDENT;
        kw_buf = {40'b0, c};
      end else begin
        case (c)
          CH_PLUS: mode = M_PLUS;
          CH_EQ:   mode = M_EQ;
          CH_BANG: mode = M_BANG;
          "*":     add(K_MULT, 1);
          "/":     add(K_DIV, 1);
          ";":     add(K_SEMI, 1);
          "(":     add(K_LPAREN, 1);
          ")":     add(K_RPAREN, 1);
          "{":     add(K_LBRACE, 1);
          "}":     add(K_RBRACE, 1);
          CH_LT:   add(K_LT, 1);
          CH_GT:   add(K_GT, 1);
          ",":     add(K_COMMA, 1);
          default: add(K_ERROR, 1);
        endcase
      end
    endfunction

    // Feeds a byte to the open token; returns 1 when the byte starts a new one.
    function bit extend_token(logic [7:0] c);
      case (mode)
        M_STR: begin
          bump();
          if (c == CH_QUOTE) begin
            add(K_LSTR, lex_cnt);
            mode = M_IDLE;
          end
          return 1'b0;
        end
        M_INT: begin
          if (digit_ch(c)) begin
            bump();
            return 1'b0;
          end
          if (c == CH_DOT) begin
            bump();
            mode = M_FRAC;
            return 1'b0;
          end
          add(K_LINT, lex_cnt);
        end
        M_FRAC: begin
          if (digit_ch(c)) begin
            bump();
            return 1'b0;
          end
          add(K_LFLOAT, lex_cnt);
        end
        M_IDENT: begin
          if (letter_ch(c) || digit_ch(c) || c == CH_UNDER) begin
            bump();
            kw_buf = {kw_buf[39:0], c};
            return 1'b0;
          end
          add(word_kind(), lex_cnt);
        end
        M_MINUS: begin
          if (digit_ch(c)) begin
            bump();
            mode = M_INT;
            return 1'b0;
          end
          if (c == CH_MINUS) begin
            add(K_SMINUS, 2);
            mode = M_IDLE;
            return 1'b0;
          end
          add(K_MINUS, 1);
        end
        M_PLUS: begin
          if (c == CH_PLUS) begin
            add(K_SPLUS, 2);
            mode = M_IDLE;
            return 1'b0;
          end
          add(K_PLUS, 1);
        end
        M_EQ: begin
          if (c == CH_EQ || c == CH_LT || c == CH_GT) begin
            add((c == CH_EQ) ? K_EQUAL : (c == CH_LT) ? K_LE : K_GE, 2);
            mode = M_IDLE;
            return 1'b0;
          end
          add(K_ASSIGN, 1);
        end
        M_BANG: begin
          if (c == CH_EQ) begin
            add(K_NE, 2);
            mode = M_IDLE;
            return 1'b0;
          end
          add(K_ERROR, 1);
        end
        default: ;
      endcase
      mode = M_IDLE;
      return 1'b1;
    endfunction

    // Called on every accepted input transfer.
    function void note_input(logic [7:0] c, logic eoi);
      step_tokens.delete();
      if (eoi) begin
        flush();
        tok_line = line_no;
        tok_off  = pos;
        lex_cnt  = 0;
        add(K_EOF, 0);
      end else begin
        if (extend_token(c)) open_token(c);
        pos = pos + 1'b1;
        if (c == CH_NL && line_no != {LINE_W{1'b1}}) line_no = line_no + 1'b1;
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    // Called on every accepted result transfer.
    function void check_token(token_t got);
      token_t want;
      if (expected_tokens.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected token: kind %0d line %0d offset %0d len %0d last %0d",
                   got.kind, got.line_no, got.offset, got.len, got.last);
        return;
      end
      want = expected_tokens.pop_front();
      if (got != want) begin
        fails++;
        if (fails <= 10)
          $display("token mismatch: expected kind %0d line %0d offset %0d len %0d last %0d,",
                   want.kind, want.line_no, want.offset, want.len, want.last,
                   " got kind %0d line %0d offset %0d len %0d last %0d",
                   got.kind, got.line_no, got.offset, got.len, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sttok_in_if  in_ch ();
  sttok_out_if out_ch ();

  source_tokenizer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  token_scoreboard sb = new();
  int  items_sent = 0;
  int  quiet_cycles = 0;
  bit  no_idle = 1'b0;

  string op_words[20] = '{"+", "++", "-", "--", "*", "/", "=", "==", "=<", "=>",
                          "<", ">", "!=", "!", ";", "(", ")", "{", "}", ","};

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Both channel monitors feed the scoreboard.
  always @(posedge clk) begin
    token_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind    = out_ch.token_kind;
        got.line_no = out_ch.start_line;
        got.offset  = out_ch.start_offset;
        got.len     = out_ch.lexeme_length;
        got.last    = out_ch.last_in_run;
        sb.check_token(got);
      end
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.char_byte, in_ch.end_of_input);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("source_tokenizer test failed");
        $finish;
      end
    end
  end

  // Token sink with a random stall before each transfer.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // One input transfer, after a random gap.
  task automatic send_item(input logic [7:0] c, input logic eoi);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_byte    <= c;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // End marker; the byte lane carries junk that the block must ignore.
  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] ident_char(input bit lead);
    int r;
    r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'(8'h30 + r - 53);
  endfunction

  task automatic send_ident(input int n);
    send_item(ident_char(1'b1), 1'b0);
    for (int i = 1; i < n; i++) send_item(ident_char(1'b0), 1'b0);
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) send_item(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
  endtask

  // String body bytes are any value but the quote, newlines now and then.
  task automatic send_string(input int n, input bit closed);
    logic [7:0] c;
    send_item(CH_QUOTE, 1'b0);
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 7) == 0) ? CH_NL : 8'($urandom_range(0, 255));
      if (c == CH_QUOTE) c = "q";
      send_item(c, 1'b0);
    end
    if (closed) send_item(CH_QUOTE, 1'b0);
  endtask

  // Mostly well-formed tokens with random content, some noise and broken input.
  task automatic send_random_token();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 18) begin
      k = $urandom_range(0, 11);
      send_text(sb.kw_text[k]);
    end else if (r < 33) begin
      send_ident($urandom_range(1, 8));
    end else if (r < 45) begin
      if ($urandom_range(0, 2) == 0) send_item(CH_MINUS, 1'b0);
      send_digits($urandom_range(1, 5));
    end else if (r < 53) begin
      if ($urandom_range(0, 3) == 0) send_item(CH_MINUS, 1'b0);
      send_digits($urandom_range(1, 3));
      send_item(CH_DOT, 1'b0);
      send_digits($urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0) begin
        send_item(CH_DOT, 1'b0);
        send_digits(1);
      end
    end else if (r < 63) begin
      send_string($urandom_range(0, 6), 1'b1);
    end else if (r < 83) begin
      send_text(op_words[$urandom_range(0, 19)]);
    end else if (r < 89) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 93) begin
      send_end();
    end else if (r < 96) begin
      send_string($urandom_range(0, 5), 1'b0);
      send_end();
    end else begin
      // Long tokens run the lexeme count into saturation.
      case ($urandom_range(0, 2))
        0:       send_ident($urandom_range(95, 110));
        1:       send_string($urandom_range(95, 110), 1'b1);
        default: send_digits($urandom_range(95, 110));
      endcase
    end
    // Separator, or none so the next token follows without a gap.
    r = $urandom_range(0, 99);
    if (r < 30) send_item(" ", 1'b0);
    else if (r < 45) send_item(CH_NL, 1'b0);
    else if (r < 60) send_item(8'(8'h09 + $urandom_range(0, 4)), 1'b0);
  endtask

  // Reset, stimulus and the final verdict.
  initial begin
    int base;
    int next_batch;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.char_byte    <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: minus forms, two-byte operators, bang, floats, newline in a string.
    send_text("-12--+++==<=>!=!;9.5.1\n\"a\nb\"");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    // Unterminated string and an open minus, each flushed by the end marker.
    send_text("\"ab");
    send_end();
    send_text("-");
    send_end();
    send_end();

    // Random part in batches, some of them without any idling.
    base       = items_sent;
    next_batch = items_sent;
    while (items_sent < base + RANDOM_ITEMS) begin
      if (items_sent >= next_batch) begin
        no_idle    = ($urandom_range(0, 3) == 0);
        next_batch = next_batch + 60;
      end
      send_random_token();
    end
    send_end();

    // A short tail across a newline, closed by the end marker.
    no_idle = 1'b0;
    send_text("ab 7\n+");
    send_end();
    in_ch.valid <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.expected_tokens.size() == 0) begin
      $display("source_tokenizer test passed");
    end else begin
      $display("source_tokenizer test failed");
    end
    $finish;
  end

endmodule

[source_tokenizer.f]
rtl/sttok_pkg.sv
rtl/sttok_if.sv
rtl/sttok_core.sv
rtl/sttok_queue.sv
rtl/source_tokenizer.sv
dv/source_tokenizer_tb.sv
